// ===== rtl/bspp_pkg.sv =====
package bspp_pkg;

    localparam int CAND_WIDTH = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_EXP_MUL,
        ST_EXP_WAIT,
        ST_EXP_DBL,
        ST_CHECK,
        ST_SQ_MUL,
        ST_SQ_WAIT
    } t_state;

    typedef struct packed {
        logic start;
    } t_mul_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

// ===== rtl/bspp_mulmod.sv =====
module bspp_mulmod import bspp_pkg::*; #(
    parameter int NUM_WIDTH = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_mul_req             i_req,
    input  logic [NUM_WIDTH-1:0] i_a,
    input  logic [NUM_WIDTH-1:0] i_b,
    input  logic [NUM_WIDTH-1:0] i_m,
    output t_mul_stat            o_stat,
    output logic [NUM_WIDTH-1:0] o_product
);

    localparam int CW = $clog2(NUM_WIDTH);
    localparam int XW = NUM_WIDTH + 2;
    localparam logic [CW-1:0] LAST = CW'(NUM_WIDTH - 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic [NUM_WIDTH-1:0] r_acc, n_acc;
    logic [NUM_WIDTH-1:0] r_a, n_a;
    logic [NUM_WIDTH-1:0] r_b, n_b;
    logic [NUM_WIDTH-1:0] r_m, n_m;

    logic [XW-1:0] sum;
    logic [XW-1:0] m1;
    logic [XW-1:0] m2;
    logic [XW-1:0] red;

    always_comb begin
        m1  = {2'b00, r_m};
        m2  = {1'b0, r_m, 1'b0};
        sum = {1'b0, r_acc, 1'b0} + (r_b[NUM_WIDTH-1] ? {2'b00, r_a} : '0);
        if (sum >= m2) begin
            red = sum - m2;
        end else if (sum >= m1) begin
            red = sum - m1;
        end else begin
            red = sum;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
        end else if (r_busy) begin
            n_acc = red[NUM_WIDTH-1:0];
            n_b   = {r_b[NUM_WIDTH-2:0], 1'b0};
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_product   = r_acc;

endmodule

// ===== rtl/base2_strong_probable_prime_top.sv =====
// channel | valid      | stall      | payload
// input   | i_in_valid | o_in_stall | i_candidate
// output  | o_out_valid| i_out_stall| o_composite, o_invalid
//
// One item at a time. The bit-serial modular multiplier works one bit per cycle.
// Candidates below two are flagged invalid and composite without a test.
// Reset is synchronous and active low; it clears the sequencer and output valid.
// A new item is taken while a result waits under stall in the output register.
module base2_strong_probable_prime_top import bspp_pkg::*; #(
    parameter int NUM_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [CAND_WIDTH-1:0] i_candidate,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_composite,
    output logic                  o_invalid
);

    localparam int CW = $clog2(NUM_WIDTH);
    localparam logic [CW-1:0] LAST = CW'(NUM_WIDTH - 1);
    localparam logic [NUM_WIDTH-1:0] ONE = NUM_WIDTH'(1);

    t_state               r_state, n_state;
    logic [NUM_WIDTH-1:0] r_n, n_n;
    logic [NUM_WIDTH-1:0] r_nm1, n_nm1;
    logic [NUM_WIDTH-1:0] r_d, n_d;
    logic [NUM_WIDTH-1:0] r_x, n_x;
    logic [CW-1:0]        r_s, n_s;
    logic [CW-1:0]        r_cnt, n_cnt;
    logic                 r_fail, n_fail;
    logic                 r_inv, n_inv;
    logic                 r_pend, n_pend;
    logic                 r_out_valid, n_out_valid;
    logic                 r_composite, n_composite;
    logic                 r_invalid, n_invalid;

    logic [NUM_WIDTH-1:0] cand;
    logic [NUM_WIDTH:0]   dbl;
    logic [NUM_WIDTH:0]   dbl_red;
    t_mul_req             mul_req;
    t_mul_stat            mul_stat;
    logic [NUM_WIDTH-1:0] mul_res;

    bspp_mulmod #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mul_req),
        .i_a       (r_x),
        .i_b       (r_x),
        .i_m       (r_n),
        .o_stat    (mul_stat),
        .o_product (mul_res)
    );

    assign cand = i_candidate[NUM_WIDTH-1:0];

    always_comb begin
        dbl = {r_x, 1'b0};
        if (dbl >= {1'b0, r_n}) begin
            dbl_red = dbl - {1'b0, r_n};
        end else begin
            dbl_red = dbl;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_nm1       = r_nm1;
        n_d         = r_d;
        n_x         = r_x;
        n_s         = r_s;
        n_cnt       = r_cnt;
        n_fail      = r_fail;
        n_inv       = r_inv;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && i_out_stall;
        n_composite = r_composite;
        n_invalid   = r_invalid;
        mul_req     = '0;
        o_in_stall  = (r_state != ST_IDLE) || r_pend;

        if (r_pend && (!r_out_valid || !i_out_stall)) begin
            n_out_valid = 1'b1;
            n_composite = r_fail;
            n_invalid   = r_inv;
            n_pend      = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    if (cand[NUM_WIDTH-1:1] == '0) begin
                        n_fail = 1'b1;
                        n_inv  = 1'b1;
                        n_pend = 1'b1;
                    end else begin
                        n_n     = cand;
                        n_nm1   = cand - ONE;
                        n_d     = cand - ONE;
                        n_s     = '0;
                        n_inv   = 1'b0;
                        n_state = ST_SPLIT;
                    end
                end
            end
            ST_SPLIT: begin
                if (!r_d[0]) begin
                    n_d = {1'b0, r_d[NUM_WIDTH-1:1]};
                    n_s = r_s + CW'(1);
                end else begin
                    n_x     = ONE;
                    n_cnt   = '0;
                    n_state = ST_EXP_MUL;
                end
            end
            ST_EXP_MUL: begin
                mul_req.start = 1'b1;
                n_state       = ST_EXP_WAIT;
            end
            ST_EXP_WAIT: begin
                if (mul_stat.done) begin
                    n_x = mul_res;
                    if (r_d[NUM_WIDTH-1]) begin
                        n_state = ST_EXP_DBL;
                    end else begin
                        n_d     = {r_d[NUM_WIDTH-2:0], 1'b0};
                        n_cnt   = r_cnt + CW'(1);
                        n_state = (r_cnt == LAST) ? ST_CHECK : ST_EXP_MUL;
                    end
                end
            end
            ST_EXP_DBL: begin
                n_x     = dbl_red[NUM_WIDTH-1:0];
                n_d     = {r_d[NUM_WIDTH-2:0], 1'b0};
                n_cnt   = r_cnt + CW'(1);
                n_state = (r_cnt == LAST) ? ST_CHECK : ST_EXP_MUL;
            end
            ST_CHECK: begin
                if (r_x == ONE) begin
                    n_fail  = 1'b0;
                    n_pend  = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_s == '0) begin
                    n_fail  = 1'b1;
                    n_pend  = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_x == r_nm1) begin
                    n_fail  = 1'b0;
                    n_pend  = 1'b1;
                    n_state = ST_IDLE;
                end else if (r_s == CW'(1)) begin
                    n_fail  = 1'b1;
                    n_pend  = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    n_s     = r_s - CW'(1);
                    n_state = ST_SQ_MUL;
                end
            end
            ST_SQ_MUL: begin
                mul_req.start = 1'b1;
                n_state       = ST_SQ_WAIT;
            end
            ST_SQ_WAIT: begin
                if (mul_stat.done) begin
                    n_x = mul_res;
                    if (mul_res == r_nm1) begin
                        n_fail  = 1'b0;
                        n_pend  = 1'b1;
                        n_state = ST_IDLE;
                    end else if (r_s == CW'(1)) begin
                        n_fail  = 1'b1;
                        n_pend  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_s     = r_s - CW'(1);
                        n_state = ST_SQ_MUL;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_n         <= n_n;
        r_nm1       <= n_nm1;
        r_d         <= n_d;
        r_x         <= n_x;
        r_s         <= n_s;
        r_cnt       <= n_cnt;
        r_fail      <= n_fail;
        r_inv       <= n_inv;
        r_composite <= n_composite;
        r_invalid   <= n_invalid;
    end

    assign o_out_valid = r_out_valid;
    assign o_composite = r_composite;
    assign o_invalid   = r_invalid;

endmodule

// ===== rtl/bspp_checker.sv =====
module bspp_checker import bspp_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic [CAND_WIDTH-1:0] i_candidate,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic                  o_composite,
    input logic                  o_invalid
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_composite) && $stable(o_invalid))
        else $error("held item changed under stall");

    a_invalid_composite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_invalid |-> o_composite)
        else $error("invalid item not marked composite");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item taken while one is at work");

    a_zero_candidate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_candidate == '0) && !o_out_valid |=>
            ##1 o_out_valid && o_invalid)
        else $error("zero candidate not flagged invalid");

endmodule

bind base2_strong_probable_prime_top bspp_checker u_bspp_checker (.*);
